/* hw/rtl/rpwa_pkg.sv */
// Shared types and constants for the rain pulse width accumulator.
`timescale 1ns / 1ps
package rpwa_pkg;

    localparam int US_W      = 26;
    localparam int ELAPSED_W = 16;
    localparam int COUNT_W   = 10;
    localparam int DROPS_W   = 9;
    localparam int HIST_W    = 15;

    localparam logic [US_W-1:0]    NOMINAL_PULSE_US = US_W'(190000);
    localparam logic [US_W-1:0]    MIN_PULSE_US     = US_W'(190000 / 2);
    localparam logic [US_W-1:0]    US_MAX           = '1;
    localparam logic [COUNT_W-1:0] COUNT_MAX        = '1;
    localparam logic [HIST_W-1:0]  HIST_OUT_MAX     = '1;
    localparam int                 DROPS_MAX        = ((1 << US_W) - 1) / 190000;

    // x / 190000 == (x * DIV_RECIP) >> DIV_SHIFT for every 26-bit x
    localparam int              DIV_SHIFT = 44;
    localparam int              RECIP_W   = 27;
    localparam longint unsigned DIV_RECIP_L =
        ((64'd1 << DIV_SHIFT) + 64'd190000 - 64'd1) / 64'd190000;
    localparam logic [RECIP_W-1:0] DIV_RECIP = RECIP_W'(DIV_RECIP_L);

    typedef enum logic {
        CMD_SAMPLE = 1'b0,
        CMD_PERIOD = 1'b1
    } t_cmd;

    typedef enum logic {
        RES_SAMPLE = 1'b0,
        RES_PERIOD = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind               kind;
        logic                pulse_done;
        logic                pulse_accepted;
        logic [US_W-1:0]     pulse_us;
        logic [DROPS_W-1:0]  pulse_drops;
        logic                raining;
        logic [COUNT_W-1:0]  period_pulses;
        logic [US_W-1:0]     period_us;
        logic [DROPS_W-1:0]  period_drops;
        logic [HIST_W-1:0]   history_sum;
    } t_result;

endpackage

/* hw/rtl/rpwa_div.sv */
// Divide a microsecond count by the nominal pulse length via reciprocal multiply.
`timescale 1ns / 1ps
module rpwa_div
    import rpwa_pkg::*;
(
    input  logic [US_W-1:0]    i_us,
    output logic [DROPS_W-1:0] o_drops
);

    localparam int PROD_W = US_W + RECIP_W;

    logic [PROD_W-1:0] prod;

    // single 26x27 multiply; ceiling reciprocal is exact over the full input range
    assign prod    = PROD_W'(i_us) * PROD_W'(DIV_RECIP);
    assign o_drops = prod[DIV_SHIFT +: DROPS_W];

endmodule

/* hw/rtl/rpwa_ring.sv */
// Drop history ring with a running sum.
`timescale 1ns / 1ps
module rpwa_ring
    import rpwa_pkg::*;
#(
    parameter int HISTORY_DEPTH = 60
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_we,
    input  logic [DROPS_W-1:0] i_drops,
    output logic [HIST_W-1:0]  o_history_sum
);

    localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int SUM_W = $clog2(HISTORY_DEPTH * DROPS_MAX + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HISTORY_DEPTH - 1);

    logic [DROPS_W-1:0] mem [HISTORY_DEPTH];

    logic [IDX_W-1:0]   r_idx, n_idx;
    logic               r_wrapped;
    logic [SUM_W-1:0]   r_sum, n_sum;
    logic [DROPS_W-1:0] r_rd;
    logic               r_byp;
    logic [DROPS_W-1:0] r_byp_data;
    logic [IDX_W-1:0]   rd_addr;
    logic [DROPS_W-1:0] old_drops;
    logic [SUM_W-1:0]   cur_sum;

    assign n_idx   = (r_idx == LAST_IDX) ? '0 : r_idx + 1'b1;
    // keep the read port parked on the slot that the next period overwrites
    assign rd_addr = i_we ? n_idx : r_idx;

    // entries are written strictly in order, so nothing is stale once wrapped
    assign old_drops = !r_wrapped ? '0 : (r_byp ? r_byp_data : r_rd);
    assign n_sum     = r_sum - SUM_W'(old_drops) + SUM_W'(i_drops);
    assign cur_sum   = i_we ? n_sum : r_sum;

    assign o_history_sum = (32'(cur_sum) > 32'(HIST_OUT_MAX)) ? HIST_OUT_MAX
                                                               : HIST_W'(cur_sum);

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[r_idx] <= i_drops;
        end
        r_rd       <= mem[rd_addr];
        r_byp      <= i_we && (rd_addr == r_idx);
        r_byp_data <= i_drops;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_wrapped <= 1'b0;
            r_sum     <= '0;
        end else if (i_we) begin
            r_idx <= n_idx;
            r_sum <= n_sum;
            if (r_idx == LAST_IDX) begin
                r_wrapped <= 1'b1;
            end
        end
    end

endmodule

/* hw/rtl/rain_pulse_width_accumulator_unit.sv */
// Top level: rain relay pulse timing, period totals and drop history.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+---------------------------------------
//  in      | sink      | i_in_valid / o_in_ready | i_command, i_pin_high, i_elapsed_us
//  out     | source    | o_out_valid/i_out_ready | o_result_kind ... o_history_sum
//
// One beat in, one beat out. Full rate: a beat can enter every cycle while the out side is not stalled.
// A beat passes through the input register, then the result register; the path between them
// holds one 26x27 reciprocal multiply for the divide by the nominal pulse length.
// Synchronous active-low reset clears the control and totals; the ring needs no clearing pass.
// A stall on the out side backs up into the input register and drops o_in_ready.
`timescale 1ns / 1ps
module rain_pulse_width_accumulator_unit
    import rpwa_pkg::*;
#(
    parameter int HISTORY_DEPTH = 60
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_command,
    input  logic                 i_pin_high,
    input  logic [ELAPSED_W-1:0] i_elapsed_us,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_result_kind,
    output logic                 o_pulse_done,
    output logic                 o_pulse_accepted,
    output logic [US_W-1:0]      o_pulse_us,
    output logic [DROPS_W-1:0]   o_pulse_drops,
    output logic                 o_raining,
    output logic [COUNT_W-1:0]   o_period_pulses,
    output logic [US_W-1:0]      o_period_us,
    output logic [DROPS_W-1:0]   o_period_drops,
    output logic [HIST_W-1:0]    o_history_sum
);

    // input register
    logic                 r_in_valid;
    t_cmd                 r_in_cmd;
    logic                 r_in_pin;
    logic [ELAPSED_W-1:0] r_in_elapsed;

    // block state
    logic                 r_last_level, n_last_level;
    logic [US_W-1:0]      r_high_time, n_high_time;
    logic [US_W-1:0]      r_period_us, n_period_us;
    logic [COUNT_W-1:0]   r_period_pulses, n_period_pulses;
    logic                 r_raining, n_raining;

    // result register
    logic                 r_out_valid;
    t_result              r_out, n_out;

    logic                 fire;
    logic                 ring_we;
    logic [US_W:0]        ht_sum;
    logic [US_W-1:0]      ht_sat;
    logic [US_W:0]        per_sum;
    logic [US_W-1:0]      div_in;
    logic [DROPS_W-1:0]   div_q;
    logic [HIST_W-1:0]    hist_sum;

    assign fire       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || fire;
    assign ring_we    = fire && (r_in_cmd == CMD_PERIOD);

    assign ht_sum  = {1'b0, r_high_time} + (US_W + 1)'(r_in_elapsed);
    assign ht_sat  = ht_sum[US_W] ? US_MAX : ht_sum[US_W-1:0];
    assign per_sum = {1'b0, r_period_us} + {1'b0, ht_sat};

    // one divider serves both the ending pulse and the closing period
    assign div_in = (r_in_cmd == CMD_PERIOD) ? r_period_us : ht_sat;

    rpwa_div u_div (
        .i_us    (div_in),
        .o_drops (div_q)
    );

    rpwa_ring #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_ring (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_we          (ring_we),
        .i_drops       (div_q),
        .o_history_sum (hist_sum)
    );

    always_comb begin
        n_last_level    = r_last_level;
        n_high_time     = r_high_time;
        n_period_us     = r_period_us;
        n_period_pulses = r_period_pulses;
        n_raining       = r_raining;
        n_out           = '0;
        n_out.kind      = RES_SAMPLE;

        case (r_in_cmd)
            CMD_SAMPLE: begin
                if (!r_last_level) begin
                    if (r_in_pin) begin
                        n_high_time = '0;
                    end
                end else if (r_in_pin) begin
                    n_high_time = ht_sat;
                end else begin
                    n_out.pulse_done  = 1'b1;
                    n_out.pulse_us    = ht_sat;
                    n_out.pulse_drops = div_q;
                    n_high_time       = '0;
                    if (ht_sat >= MIN_PULSE_US) begin
                        n_out.pulse_accepted = 1'b1;
                        n_raining            = 1'b1;
                        n_period_us          = per_sum[US_W] ? US_MAX : per_sum[US_W-1:0];
                        if (r_period_pulses != COUNT_MAX) begin
                            n_period_pulses = r_period_pulses + 1'b1;
                        end
                    end
                end
                n_last_level = r_in_pin;
            end
            CMD_PERIOD: begin
                n_out.kind          = RES_PERIOD;
                n_out.period_pulses = r_period_pulses;
                n_out.period_us     = r_period_us;
                n_out.period_drops  = div_q;
                // zero drops is the same as a total below one nominal pulse
                if (r_period_us < NOMINAL_PULSE_US) begin
                    n_raining = 1'b0;
                end
                n_period_us     = '0;
                n_period_pulses = '0;
            end
            default: begin
                n_last_level = r_last_level;
            end
        endcase

        n_out.raining     = n_raining;
        n_out.history_sum = hist_sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_last_level    <= 1'b0;
            r_high_time     <= '0;
            r_period_us     <= '0;
            r_period_pulses <= '0;
            r_raining       <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (fire) begin
                r_out_valid     <= 1'b1;
                r_last_level    <= n_last_level;
                r_high_time     <= n_high_time;
                r_period_us     <= n_period_us;
                r_period_pulses <= n_period_pulses;
                r_raining       <= n_raining;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_cmd     <= t_cmd'(i_command);
            r_in_pin     <= i_pin_high;
            r_in_elapsed <= i_elapsed_us;
        end
        if (fire) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_result_kind    = r_out.kind;
    assign o_pulse_done     = r_out.pulse_done;
    assign o_pulse_accepted = r_out.pulse_accepted;
    assign o_pulse_us       = r_out.pulse_us;
    assign o_pulse_drops    = r_out.pulse_drops;
    assign o_raining        = r_out.raining;
    assign o_period_pulses  = r_out.period_pulses;
    assign o_period_us      = r_out.period_us;
    assign o_period_drops   = r_out.period_drops;
    assign o_history_sum    = r_out.history_sum;

    a_done_is_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_pulse_done |-> o_result_kind == RES_SAMPLE)
        else $error("pulse end flagged on a period summary");

    a_accept_needs_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_pulse_accepted |-> o_pulse_done && (o_pulse_us >= MIN_PULSE_US))
        else $error("accepted pulse is short or not ended");

    a_period_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ring_we |=> (r_period_us == '0) && (r_period_pulses == '0))
        else $error("period totals not cleared at period end");

    a_summary_raining: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_result_kind == RES_PERIOD)
            |-> o_raining == (o_period_us >= NOMINAL_PULSE_US))
        else $error("raining flag disagrees with period total");

endmodule
